[hw/rtl/fsub_pkg.sv]
// Shared types, constants and helpers for the first substring match block.
`default_nettype none
package fsub_pkg;

    localparam int PATTERN_MAX    = 32;
    localparam int INDEX_BITS     = 32;
    localparam int LEN_BITS       = 6;
    localparam int POS_BITS       = $clog2(PATTERN_MAX);
    localparam int PATTERN_BITS   = PATTERN_MAX * 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;

    localparam logic [INDEX_BITS-1:0] COUNT_MAX = {INDEX_BITS{1'b1}};

    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_BYTES_0 = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_BYTES_1 = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_BYTES_2 = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_BYTES_3 = 3'd4;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic                  found;
        logic [INDEX_BITS-1:0] index;
    } result_t;

    function automatic logic [7:0] pattern_byte(input logic [PATTERN_BITS-1:0] pattern,
                                                input logic [POS_BITS-1:0]     pos);
        return pattern[8*pos +: 8];
    endfunction

endpackage
`default_nettype wire

[hw/rtl/first_substring_match.sv]
// Top level of the first substring match block: config, cell chain and result queue.
//
// Usage:
//   Write pattern_length (index 0) and pattern_bytes_0..3 (index 1..4) on the cfg
//   channel; cfg_ready is always high. Stream source bytes on s_axis, one byte per
//   transaction, tlast on the final byte of a source. Each tlast transaction yields
//   one m_axis transaction: tuser = match found, tdata = first start index (0 when
//   not found).
// Timing:
//   One byte per cycle while the result queue has room. The new byte enters the 32-cell
//   window chain and all cells compare in parallel in the same cycle; the result is
//   registered into the result queue and shows on m_axis from its head entry.
// Reset:
//   Pattern length 1, pattern bytes zero, window, byte count and match latch clear.
//   The same per-source state clears after every tlast transaction.
// Stall:
//   Results wait in a two-entry queue; s_axis_tready drops only while both entries
//   are held by a stalled receiver.
`default_nettype none
module first_substring_match
    import fsub_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [7:0]                s_axis_tdata,   // [7:0] source_byte
    input  wire logic                      s_axis_tlast,   // end of source mark
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [INDEX_BITS-1:0]          m_axis_tdata,   // [31:0] match_index
    output logic                           m_axis_tuser    // match_found
);

    logic [LEN_BITS-1:0]     length_reg;
    logic [LEN_BITS-1:0]     length_next;
    logic [PATTERN_BITS-1:0] pattern_reg;
    logic [PATTERN_BITS-1:0] pattern_next;
    logic [INDEX_BITS-1:0]   seen_reg;
    logic [INDEX_BITS-1:0]   seen_next;
    logic                    have_reg;
    logic                    have_next;
    logic [INDEX_BITS-1:0]   index_reg;
    logic [INDEX_BITS-1:0]   index_next;

    logic                    cfg_write;
    logic                    accept;
    logic                    advance;
    logic                    hit;
    logic                    queue_full;
    logic [LEN_BITS-1:0]     len_used;
    logic [INDEX_BITS-1:0]   seen_inc;
    logic                    new_have;
    logic [INDEX_BITS-1:0]   new_index;
    cell_ctrl_t              cell_ctrl;
    result_t                 result;
    result_t                 out_data;
    logic [7:0]              chain   [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0]  cell_eq;

    assign cfg_ready     = 1'b1;
    assign cfg_write     = cfg_valid && cfg_ready;
    assign s_axis_tready = !queue_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign advance       = accept && (seen_reg != COUNT_MAX);

    always_comb
    begin
        len_used = length_reg;
        if (length_reg == '0)
        begin
            len_used = LEN_BITS'(1);
        end
        else if (length_reg > LEN_BITS'(PATTERN_MAX))
        begin
            len_used = LEN_BITS'(PATTERN_MAX);
        end
    end

    always_comb
    begin
        length_next  = length_reg;
        pattern_next = pattern_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_PATTERN_LENGTH:  length_next = cfg_data[LEN_BITS-1:0];
                REG_PATTERN_BYTES_0: pattern_next[0*64 +: 64] = cfg_data;
                REG_PATTERN_BYTES_1: pattern_next[1*64 +: 64] = cfg_data;
                REG_PATTERN_BYTES_2: pattern_next[2*64 +: 64] = cfg_data;
                REG_PATTERN_BYTES_3: pattern_next[3*64 +: 64] = cfg_data;
                default:             length_next = length_reg;
            endcase
        end
    end

    assign cell_ctrl.shift = advance && !s_axis_tlast;
    assign cell_ctrl.clear = accept && s_axis_tlast;
    assign chain[0]        = s_axis_tdata[7:0];

    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            logic [POS_BITS-1:0] pos;
            logic                active;

            assign active = (LEN_BITS'(k) < len_used);
            assign pos    = POS_BITS'(len_used - LEN_BITS'(1) - LEN_BITS'(k));

            fsub_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (cell_ctrl),
                .byte_in     (chain[k]),
                .expect_byte (pattern_byte(pattern_reg, pos)),
                .active      (active),
                .byte_out    (chain[k+1]),
                .eq          (cell_eq[k])
            );
        end
    endgenerate

    assign seen_inc  = seen_reg + INDEX_BITS'(1);
    assign hit       = advance && !have_reg && (seen_inc >= INDEX_BITS'(len_used)) && (&cell_eq);
    assign new_have  = have_reg || hit;
    assign new_index = hit ? (seen_inc - INDEX_BITS'(len_used)) : index_reg;

    always_comb
    begin
        seen_next  = seen_reg;
        have_next  = have_reg;
        index_next = index_reg;
        if (accept && s_axis_tlast)
        begin
            seen_next  = '0;
            have_next  = 1'b0;
            index_next = '0;
        end
        else if (advance)
        begin
            seen_next  = seen_inc;
            have_next  = new_have;
            index_next = new_index;
        end
    end

    assign result.found = new_have;
    assign result.index = new_have ? new_index : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg  <= LEN_BITS'(1);
            pattern_reg <= '0;
            seen_reg    <= '0;
            have_reg    <= 1'b0;
            index_reg   <= '0;
        end
        else
        begin
            length_reg  <= length_next;
            pattern_reg <= pattern_next;
            seen_reg    <= seen_next;
            have_reg    <= have_next;
            index_reg   <= index_next;
        end
    end

    fsub_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && s_axis_tlast),
        .push_data (result),
        .full      (queue_full),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_data)
    );

    assign m_axis_tdata = out_data.index;
    assign m_axis_tuser = out_data.found;

endmodule
`default_nettype wire

[hw/rtl/fsub_cell.sv]
// One window cell: holds one source byte, passes it on and compares the arriving byte.
`default_nettype none
module fsub_cell
    import fsub_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire logic [7:0] byte_in,
    input  wire logic [7:0] expect_byte,
    input  wire logic       active,
    output logic      [7:0] byte_out,
    output logic            eq
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = 8'd0;
        end
        else if (ctrl.shift)
        begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;
    assign eq       = !active || (byte_in == expect_byte);

endmodule
`default_nettype wire

[hw/rtl/fsub_out_queue.sv]
// Two-entry result queue between the match logic and the output stream.
`default_nettype none
module fsub_out_queue
    import fsub_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         full,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    result_t    slot0_reg;
    result_t    slot0_next;
    result_t    slot1_reg;
    result_t    slot1_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop = (count_reg != 2'd0) && out_ready;

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    slot0_next = push_data;
                end
                else
                begin
                    slot1_next = push_data;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                slot0_next = slot1_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    slot0_next = push_data;
                end
                else
                begin
                    slot0_next = slot1_reg;
                    slot1_next = push_data;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot0_reg;

endmodule
`default_nettype wire

[tb/first_substring_match_checker.sv]
// Checker for the first substring match block: predicts search results and compares them.
`default_nettype none
module first_substring_match_checker
    import fsub_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    input  wire logic                      cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                      s_axis_tvalid,
    input  wire logic                      s_axis_tready,
    input  wire logic [7:0]                s_axis_tdata,   // [7:0] source_byte
    input  wire logic                      s_axis_tlast,   // end of source mark
    input  wire logic                      m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    input  wire logic [INDEX_BITS-1:0]     m_axis_tdata,   // [31:0] match_index
    input  wire logic                      m_axis_tuser,   // match_found
    output int                             failures,
    output int                             outstanding,
    output int                             results_seen,
    output int                             matches_seen
);

    logic [LEN_BITS-1:0]      len_reg;
    logic [63:0]              pat_word [4];
    logic [7:0]               window [PATTERN_MAX];
    logic [INDEX_BITS-1:0]    seen_count;
    logic                     latched;
    logic [INDEX_BITS-1:0]    latched_index;
    result_t                  search_results_q [$];

    function automatic int effective_length();
        if (len_reg == 0)
            return 1;
        if (len_reg > PATTERN_MAX)
            return PATTERN_MAX;
        return int'(len_reg);
    endfunction

    function automatic logic [7:0] pattern_at(input int k);
        return pat_word[k >> 3][(k & 7) * 8 +: 8];
    endfunction

    task automatic clear_search();
        int i;
        for (i = 0; i < PATTERN_MAX; i++)
            window[i] = 8'h00;
        seen_count    = '0;
        latched       = 1'b0;
        latched_index = '0;
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0]  value);
        case (idx)
            REG_PATTERN_LENGTH:  len_reg     = value[LEN_BITS-1:0];
            REG_PATTERN_BYTES_0: pat_word[0] = value;
            REG_PATTERN_BYTES_1: pat_word[1] = value;
            REG_PATTERN_BYTES_2: pat_word[2] = value;
            REG_PATTERN_BYTES_3: pat_word[3] = value;
            default: ;
        endcase
    endtask

    task automatic search_byte(input logic [7:0] b, input logic last);
        int      len;
        int      i;
        bit      hit;
        result_t r;
        if (seen_count != COUNT_MAX)
        begin
            len = effective_length();
            for (i = PATTERN_MAX - 1; i > 0; i--)
                window[i] = window[i-1];
            window[0] = b;
            seen_count++;
            if (!latched && seen_count >= len)
            begin
                hit = 1'b1;
                for (i = 0; i < len; i++)
                    if (window[i] != pattern_at(len - 1 - i))
                        hit = 1'b0;
                if (hit)
                begin
                    latched       = 1'b1;
                    latched_index = seen_count - len;
                end
            end
        end
        if (last)
        begin
            r.found = latched;
            r.index = latched ? latched_index : '0;
            search_results_q.push_back(r);
            clear_search();
        end
    endtask

    task automatic report_mismatch(input string msg);
        failures++;
        if (failures <= 40)
            $display("%0t: mismatch: %s", $time, msg);
    endtask

    task automatic check_result(input logic found, input logic [INDEX_BITS-1:0] index);
        result_t want;
        results_seen++;
        if (found)
            matches_seen++;
        if (search_results_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result found=%0b index=%0d", found, index));
        end
        else
        begin
            want = search_results_q.pop_front();
            if (found !== want.found)
                report_mismatch($sformatf("match_found got %0b want %0b", found, want.found));
            if (index !== want.index)
                report_mismatch($sformatf("match_index got %0d want %0d", index, want.index));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg = LEN_BITS'(1);
            for (int w = 0; w < 4; w++)
                pat_word[w] = '0;
            clear_search();
            search_results_q.delete();
            failures     = 0;
            outstanding  = 0;
            results_seen = 0;
            matches_seen = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tuser, m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                search_byte(s_axis_tdata, s_axis_tlast);
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);
            outstanding = search_results_q.size();
        end
    end

endmodule
`default_nettype wire

[tb/first_substring_match_tb.sv]
// Testbench top for the first substring match block: stimulus, idling phases and verdict.
`default_nettype none
module first_substring_match_tb;
    import fsub_pkg::*;

    localparam int BYTE_TARGET  = 1700;
    localparam int WATCHDOG_MAX = 4000;
    localparam int DRAIN_CYCLES = 6;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata;
    logic                      s_axis_tlast;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [INDEX_BITS-1:0]     m_axis_tdata;
    logic                      m_axis_tuser;

    int failures;
    int outstanding;
    int results_seen;
    int matches_seen;

    int send_idle;
    int recv_stall;
    int stall_cycles;
    int bytes_sent;
    int sources_sent;
    int settings_used;
    int phase_no;
    int eff_len;
    int src_len;
    int pos;
    int k;
    int r;
    logic [LEN_BITS-1:0]     len_sel;
    logic [PATTERN_BITS-1:0] cur_pattern;
    logic [7:0]              src_q [$];

    first_substring_match dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    first_substring_match_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .failures      (failures),
        .outstanding   (outstanding),
        .results_seen  (results_seen),
        .matches_seen  (matches_seen)
    );

    always #6 clk = ~clk;

    always @(negedge clk)
        m_axis_tready = ($urandom_range(0, 99) >= recv_stall);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !rst_n)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_MAX)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0]  value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_pattern(input logic [PATTERN_BITS-1:0] pattern);
        cur_pattern = pattern;
        write_reg(REG_PATTERN_BYTES_0, pattern[63:0]);
        write_reg(REG_PATTERN_BYTES_1, pattern[127:64]);
        write_reg(REG_PATTERN_BYTES_2, pattern[191:128]);
        write_reg(REG_PATTERN_BYTES_3, pattern[255:192]);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_source(input bit close);
        int i;
        for (i = 0; i < src_q.size(); i++)
            send_byte(src_q[i], close && (i == src_q.size() - 1));
        s_axis_tvalid = 1'b0;
        if (close)
            sources_sent++;
    endtask

    // hold the sender until every result is back, then let the pipeline settle
    task automatic wait_idle();
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 67; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 67; end
            default: begin send_idle = 22; recv_stall = 22; end
        endcase
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_PATTERN_LENGTH;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        send_idle     = 0;
        recv_stall    = 0;
        stall_cycles  = 0;
        bytes_sent    = 0;
        sources_sent  = 0;
        settings_used = 1;
        cur_pattern   = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: single zero byte
        src_q = '{8'h00};
        send_source(1);

        // first match latched, later one ignored
        wait_idle();
        write_reg(REG_PATTERN_LENGTH, 64'd3);
        write_pattern({{(PATTERN_BITS-24){1'b1}}, 24'h8000FF});
        src_q = '{8'hFF, 8'h00, 8'h80, 8'hFF, 8'h00, 8'h80};
        send_source(1);
        src_q = '{8'h01, 8'hFF, 8'h00};
        send_source(1);

        // pattern longer than the source
        wait_idle();
        write_reg(REG_PATTERN_LENGTH, 64'd5);
        src_q = '{8'hFF, 8'h00, 8'h80, 8'hFF};
        send_source(1);

        // zero length acts as one byte
        wait_idle();
        write_reg(REG_PATTERN_LENGTH, 64'd0);
        write_pattern({{(PATTERN_BITS-8){1'b0}}, 8'h7F});
        src_q = '{8'h12, 8'h7F};
        send_source(1);

        // rewrite the pattern in the middle of a source
        wait_idle();
        write_reg(REG_PATTERN_LENGTH, 64'd2);
        write_pattern({{(PATTERN_BITS-16){1'b0}}, 16'hBBAA});
        src_q = '{8'hAA};
        send_source(0);
        wait_idle();
        write_pattern({{(PATTERN_BITS-16){1'b0}}, 16'hDDCC});
        src_q = '{8'hCC, 8'hDD};
        send_source(1);
        settings_used += 5;

        phase_no = 0;
        while (bytes_sent < BYTE_TARGET)
        begin
            wait_idle();
            set_idling(phase_no);
            r = $urandom_range(0, 19);
            if (r == 0)
                len_sel = LEN_BITS'(1);
            else if (r == 1)
                len_sel = LEN_BITS'(PATTERN_MAX);
            else if (r == 2)
                len_sel = LEN_BITS'(0);
            else if (r == 3)
                len_sel = LEN_BITS'($urandom_range(PATTERN_MAX + 1, 63));
            else if (r < 8)
                len_sel = LEN_BITS'($urandom_range(9, PATTERN_MAX));
            else
                len_sel = LEN_BITS'($urandom_range(1, 8));
            eff_len = (len_sel == 0) ? 1 : (len_sel > PATTERN_MAX) ? PATTERN_MAX : len_sel;
            write_reg(REG_PATTERN_LENGTH, CFG_DATA_BITS'(len_sel));
            write_pattern({$urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom});
            settings_used++;
            repeat ($urandom_range(4, 12))
            begin
                src_len = $urandom_range(1, eff_len + 16);
                src_q.delete();
                for (k = 0; k < src_len; k++)
                    if ($urandom_range(0, 1) != 0)
                        src_q.push_back(cur_pattern[8 * $urandom_range(0, eff_len - 1) +: 8]);
                    else
                        src_q.push_back(8'($urandom));
                if ($urandom_range(0, 99) < 65 && src_len >= eff_len)
                begin
                    pos = $urandom_range(0, src_len - eff_len);
                    for (k = 0; k < eff_len; k++)
                        src_q[pos + k] = cur_pattern[8 * k +: 8];
                end
                send_source(1);
            end
            phase_no++;
        end

        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("covered %0d bytes in %0d sources over %0d pattern settings",
                 bytes_sent, sources_sent, settings_used);
        $display("checked %0d results, %0d of them with a match", results_seen, matches_seen);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire

[filelist.f]
hw/rtl/fsub_pkg.sv
hw/rtl/fsub_cell.sv
hw/rtl/fsub_out_queue.sv
hw/rtl/first_substring_match.sv
tb/first_substring_match_checker.sv
tb/first_substring_match_tb.sv
